[rtl/core/cdgf_pkg.sv]
`default_nettype none
package cdgf_pkg;

  localparam int unsigned DepthW = 18;
  localparam int unsigned StepW  = 4;
  localparam int unsigned TolW   = 18;
  localparam int unsigned CfgW   = 18;
  localparam int unsigned IdxW   = 1;

  localparam logic [IdxW-1:0] RegWindowStep = 1'd0;
  localparam logic [IdxW-1:0] RegPairTol    = 1'd1;

  localparam logic [StepW-1:0] StepReset = 4'd5;
  localparam logic [TolW-1:0]  TolReset  = 18'd1000;

  typedef struct packed {
    logic [DepthW-1:0] depth_mm;
    logic              column_end;
  } in_beat_t;

  typedef struct packed {
    logic [DepthW-1:0] repaired_mm;
    logic              column_done;
  } out_beat_t;

endpackage
`default_nettype wire

[rtl/core/column_depth_gap_fill_top.sv]
`default_nettype none
// path: an input beat is registered in the front job register, then the back end
// captures it (Idle), picks the pixel (Pick) and loads the output register (Out);
// a hole adds a serial pair scan then a restoring divider (Scan, Div) before Out;
// the front takes one beat per job and stalls while a job waits for the back end
// reset: window_step 5, tolerance 1000 mm, column window empty
// output register holds a beat while the back end picks the next pixel
module column_depth_gap_fill_top import cdgf_pkg::*; #(
  parameter int unsigned MaxStep = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire in_beat_t        in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output out_beat_t            out_data_o,
  input  wire logic            cfg_we_i,
  input  wire logic [IdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i
);
  localparam int unsigned CntW = $clog2(MaxStep + 1);

  logic [StepW-1:0] step_q;
  logic [TolW-1:0]  tol_q;
  logic [CntW-1:0]  reach_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
      tol_q  <= TolReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWindowStep: step_q <= cfg_data_i[StepW-1:0];
        RegPairTol:    tol_q  <= cfg_data_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if ({28'd0, step_q} > 32'(MaxStep)) begin
      reach_w = CntW'(MaxStep - 1);
    end else if (step_q == '0) begin
      reach_w = '0;
    end else begin
      reach_w = CntW'(step_q - 4'd1);
    end
  end

  logic                 jv, js, jend;
  logic [DepthW-1:0]    jq [MaxStep];
  logic [CntW-1:0]      jn, je;
  logic [DepthW-1:0]    out_depth_w;
  logic                 out_done_w;

  cdgf_front #(.MaxStep(MaxStep), .DepthBits(DepthW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .in_depth_i(in_data_i.depth_mm), .in_end_i(in_data_i.column_end),
    .reach_i(reach_w), .job_valid_o(jv), .job_stall_i(js),
    .job_q_o(jq), .job_n_o(jn), .job_emit_o(je), .job_end_o(jend)
  );

  cdgf_back #(.MaxStep(MaxStep), .DepthBits(DepthW)) u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_stall_o(js),
    .job_q_i(jq), .job_n_i(jn), .job_emit_i(je), .job_end_i(jend),
    .reach_i(reach_w), .tol_i(tol_q), .out_valid_o, .out_stall_i,
    .out_depth_o(out_depth_w), .out_done_o(out_done_w)
  );

  assign out_data_o = '{repaired_mm: out_depth_w, column_done: out_done_w};

endmodule
`default_nettype wire

[rtl/core/cdgf_front.sv]
`default_nettype none
// front: holds the raw lookahead window and decides which pixels are due
module cdgf_front import cdgf_pkg::*; #(
  parameter int unsigned MaxStep = 8,
  parameter int unsigned DepthBits = 18,
  localparam int unsigned HistLen = MaxStep - 1,
  localparam int unsigned CntW = $clog2(MaxStep + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [DepthBits-1:0] in_depth_i,
  input  wire logic                 in_end_i,
  input  wire logic [CntW-1:0]      reach_i,
  // job to back: window snapshot, pixel count n, emit count
  output logic                      job_valid_o,
  input  wire logic                 job_stall_i,
  output logic [DepthBits-1:0]      job_q_o [MaxStep],
  output logic [CntW-1:0]           job_n_o,
  output logic [CntW-1:0]           job_emit_o,
  output logic                      job_end_o
);

  logic [DepthBits-1:0] la_q [HistLen];
  logic [DepthBits-1:0] la_d [HistLen];
  logic [DepthBits-1:0] snap_w [MaxStep];
  logic [DepthBits-1:0] jq_q [MaxStep];
  logic [CntW-1:0]      jn_q, je_q;
  logic                 jend_q;
  logic [CntW-1:0]      fill_q, fill_d;
  logic [CntW-1:0]      n_w, emit_w;
  logic                 acc;

  assign in_stall_o = job_valid_o & job_stall_i;
  assign acc = in_valid_i & ~in_stall_o;

  always_comb begin
    n_w = fill_q + CntW'(1);
    if (in_end_i) begin
      emit_w = n_w;
    end else if (n_w > reach_i) begin
      emit_w = n_w - reach_i;
    end else begin
      emit_w = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < MaxStep; k++) begin
      if (k < HistLen && CntW'(k) < fill_q) begin
        snap_w[k] = la_q[(k < HistLen) ? k : 0];
      end else if (CntW'(k) == fill_q) begin
        snap_w[k] = in_depth_i;
      end else begin
        snap_w[k] = '0;
      end
    end
  end

  // shift remaining pixels down by the emit count
  always_comb begin
    for (int k = 0; k < HistLen; k++) begin
      la_d[k] = '0;
      for (int s = 0; s < MaxStep; s++) begin
        if (CntW'(s) == CntW'(k) + emit_w) begin
          la_d[k] = snap_w[s];
        end
      end
    end
    if (in_end_i) begin
      fill_d = '0;
    end else if (n_w - emit_w > CntW'(HistLen)) begin
      fill_d = CntW'(HistLen);
    end else begin
      fill_d = n_w - emit_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      job_valid_o <= 1'b0;
    end else begin
      if (acc) begin
        fill_q <= fill_d;
      end
      if (acc) begin
        job_valid_o <= 1'b1;
      end else if (!job_stall_i) begin
        job_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      la_q   <= la_d;
      jq_q   <= snap_w;
      jn_q   <= n_w;
      je_q   <= emit_w;
      jend_q <= in_end_i;
    end
  end
  assign job_q_o    = jq_q;
  assign job_n_o    = jn_q;
  assign job_emit_o = je_q;
  assign job_end_o  = jend_q;

endmodule
`default_nettype wire

[rtl/core/cdgf_back.sv]
`default_nettype none
// back: emits pixels of one job, filling holes by a serial pair scan and divider
module cdgf_back import cdgf_pkg::*; #(
  parameter int unsigned MaxStep = 8,
  parameter int unsigned DepthBits = 18,
  localparam int unsigned HistLen = MaxStep - 1,
  localparam int unsigned CntW = $clog2(MaxStep + 1),
  localparam int unsigned QIdxW = $clog2(MaxStep),
  localparam int unsigned HIdxW = (HistLen > 1) ? $clog2(HistLen) : 1,
  localparam int unsigned PairW = $clog2(HistLen * HistLen * 2 + 1),
  localparam int unsigned SumW = DepthBits + 1 + PairW,
  localparam int unsigned BitW = $clog2(SumW + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 job_valid_i,
  output logic                      job_stall_o,
  input  wire logic [DepthBits-1:0] job_q_i [MaxStep],
  input  wire logic [CntW-1:0]      job_n_i,
  input  wire logic [CntW-1:0]      job_emit_i,
  input  wire logic                 job_end_i,
  input  wire logic [CntW-1:0]      reach_i,
  input  wire logic [TolW-1:0]      tol_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DepthBits-1:0]      out_depth_o,
  output logic                      out_done_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPick = 5'b00010,
    StScan = 5'b00100,
    StDiv  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e               state_q;
  logic [DepthBits-1:0] hist_q [HistLen];
  logic [DepthBits-1:0] jobq_q [MaxStep];
  logic [CntW-1:0]      jobn_q, jobe_q;
  logic                 jobend_q;
  logic [CntW-1:0]      hfill_q, idx_q, i_q, j_q;
  logic [SumW-1:0]      sum_q, rem_q;
  logic [PairW-1:0]     cnt_q;
  logic [SumW-1:0]      quo_q;
  logic [BitW-1:0]      bit_q;
  logic [DepthBits-1:0] val_q;
  logic                 done_q;

  logic [DepthBits-1:0] a_w, b_w, d_w, cur_w;
  logic [CntW:0]        bsel_w;
  logic                 ok_w, last_w, jlast_w, ilast_w;
  logic [SumW:0]        trial_w;

  assign cur_w   = jobq_q[idx_q[QIdxW-1:0]];
  assign a_w     = hist_q[HIdxW'(i_q - CntW'(1))];
  assign bsel_w  = {1'b0, idx_q} + {1'b0, j_q};
  assign b_w     = (bsel_w < (CntW+1)'(MaxStep)) ? jobq_q[QIdxW'(bsel_w)] : '0;
  assign d_w     = (a_w > b_w) ? a_w - b_w : b_w - a_w;
  assign ok_w    = (a_w > DepthBits'(1)) && (b_w > DepthBits'(1)) &&
                   ({{(32-DepthBits){1'b0}}, d_w} < {14'd0, tol_i}) &&
                   (i_q <= hfill_q) && (idx_q + j_q < jobn_q);
  assign last_w  = (idx_q + CntW'(1) == jobe_q);
  assign jlast_w = (j_q >= reach_i);
  assign ilast_w = (i_q >= reach_i) || (i_q >= hfill_q);
  assign trial_w = {rem_q, quo_q[SumW-1]} - {{(SumW+1-PairW){1'b0}}, cnt_q};

  assign job_stall_o = !(state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hfill_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          idx_q <= '0;
          if (job_valid_i) begin
            jobq_q   <= job_q_i;
            jobn_q   <= job_n_i;
            jobe_q   <= job_emit_i;
            jobend_q <= job_end_i;
            state_q  <= (job_emit_i == '0) ? StIdle : StPick;
          end
        end
        StPick: begin
          done_q <= last_w & jobend_q;
          if (cur_w != '0) begin
            val_q   <= cur_w;
            state_q <= StOut;
          end else if (reach_i == '0 || hfill_q == '0) begin
            val_q   <= '0;
            state_q <= StOut;
          end else begin
            i_q     <= CntW'(1);
            j_q     <= CntW'(1);
            sum_q   <= '0;
            cnt_q   <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          if (ok_w) begin
            sum_q <= sum_q + SumW'(a_w) + SumW'(b_w);
            cnt_q <= cnt_q + PairW'(2);
          end
          if (jlast_w) begin
            j_q <= CntW'(1);
            i_q <= i_q + CntW'(1);
            if (ilast_w) begin
              state_q <= StDiv;
              bit_q   <= '0;
            end
          end else begin
            j_q <= j_q + CntW'(1);
          end
          if (jlast_w && ilast_w) begin
            quo_q <= ok_w ? sum_q + SumW'(a_w) + SumW'(b_w) : sum_q;
            rem_q <= '0;
          end
        end
        StDiv: begin
          if (cnt_q == '0) begin
            val_q   <= '0;
            state_q <= StOut;
          end else if (bit_q == BitW'(SumW)) begin
            val_q   <= quo_q[DepthBits-1:0];
            state_q <= StOut;
          end else begin
            bit_q <= bit_q + BitW'(1);
            if (!trial_w[SumW]) begin
              rem_q <= trial_w[SumW-1:0];
              quo_q <= {quo_q[SumW-2:0], 1'b1};
            end else begin
              rem_q <= {rem_q[SumW-2:0], quo_q[SumW-1]};
              quo_q <= {quo_q[SumW-2:0], 1'b0};
            end
          end
        end
        StOut: begin
          if (!out_valid_o) begin
            out_valid_o <= 1'b1;
            out_depth_o <= val_q;
            out_done_o  <= done_q;
            for (int k = HistLen - 1; k > 0; k--) begin
              hist_q[k] <= hist_q[k-1];
            end
            hist_q[0] <= val_q;
            if (done_q) begin
              hfill_q <= '0;
            end else if (hfill_q < CntW'(HistLen)) begin
              hfill_q <= hfill_q + CntW'(1);
            end
            idx_q   <= idx_q + CntW'(1);
            state_q <= last_w ? StIdle : StPick;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (out_valid_o && !out_stall_i && !(state_q == StOut)) begin
        out_valid_o <= 1'b0;
      end else if (out_valid_o && !out_stall_i && state_q == StOut) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  property p_done_last;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_done_o && !out_stall_i) |=> (hfill_q == '0);
  endproperty
  a_done_last: assert property (p_done_last) else $error("fill not cleared");

  property p_hfill_max;
    @(posedge clk_i) disable iff (!rst_ni) hfill_q <= CntW'(HistLen);
  endproperty
  a_hfill_max: assert property (p_hfill_max) else $error("history overflow");

  property p_cnt_even;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == StDiv) |-> !cnt_q[0];
  endproperty
  a_cnt_even: assert property (p_cnt_even) else $error("odd pair count");

endmodule
`default_nettype wire

[tb/column_depth_gap_fill_checker.sv]
`timescale 1ns / 1ps
module column_depth_gap_fill_checker import cdgf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_stall_i,
  input  wire in_beat_t        in_data_i,
  input  wire logic            out_valid_i,
  input  wire logic            out_stall_i,
  input  wire out_beat_t       out_data_i,
  input  wire logic            cfg_we_i,
  input  wire logic [IdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  localparam int HistLen = 7;

  logic [DepthW-1:0] repaired_hist[HistLen];
  logic [DepthW-1:0] raw_ahead[HistLen];
  int unsigned       hist_cnt;
  int unsigned       ahead_cnt;
  logic [StepW-1:0]  step_reg;
  logic [TolW-1:0]   tol_reg;
  out_beat_t         pixel_q[$];

  assign pending_o = pixel_q.size();

  function automatic int unsigned window_reach();
    int unsigned s;
    s = step_reg;
    if (s > 8) s = 8;
    return (s == 0) ? 0 : s - 1;
  endfunction

  function automatic logic [DepthW-1:0] hole_mean(logic [DepthW-1:0] col[8], int unsigned idx,
                                                   int unsigned n, int unsigned r);
    longint unsigned sum, cnt;
    logic [DepthW-1:0] a, b, d;
    sum = 0;
    cnt = 0;
    for (int unsigned i = 1; i <= r && i <= hist_cnt && i <= HistLen; i++) begin
      a = repaired_hist[i-1];
      for (int unsigned j = 1; j <= r && idx + j < n; j++) begin
        b = col[idx+j];
        d = (a > b) ? a - b : b - a;
        if (a > 1 && b > 1 && d < tol_reg) begin
          sum += a + b;
          cnt += 2;
        end
      end
    end
    if (cnt == 0) return '0;
    return DepthW'(sum / cnt);
  endfunction

  task automatic predict_column(in_beat_t beat);
    logic [DepthW-1:0] col[8];
    logic [DepthW-1:0] v;
    int unsigned n, r, idx, m;
    out_beat_t o;
    int first;
    n = (ahead_cnt > HistLen) ? HistLen : ahead_cnt;
    r = window_reach();
    idx = 0;
    first = pixel_q.size();
    for (int k = 0; k < 8; k++) col[k] = (k < n) ? raw_ahead[k] : '0;
    col[n] = beat.depth_mm;
    n++;
    while (idx < n && (beat.column_end || n - idx > r)) begin
      v = col[idx];
      if (v == 0) v = hole_mean(col, idx, n, r);
      o.repaired_mm = v;
      o.column_done = 1'b0;
      pixel_q = {pixel_q, o};
      for (int k = HistLen - 1; k > 0; k--) repaired_hist[k] = repaired_hist[k-1];
      repaired_hist[0] = v;
      if (hist_cnt < HistLen) hist_cnt++;
      idx++;
    end
    if (beat.column_end) begin
      if (pixel_q.size() > first) pixel_q[pixel_q.size()-1].column_done = 1'b1;
      hist_cnt = 0;
      ahead_cnt = 0;
    end else begin
      m = 0;
      for (int unsigned k = idx; k < n && m < HistLen; k++) begin
        raw_ahead[m] = col[k];
        m++;
      end
      ahead_cnt = m;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_beat;
    if (!rst_ni) begin
      for (int k = 0; k < HistLen; k++) begin
        repaired_hist[k] = '0;
        raw_ahead[k] = '0;
      end
      hist_cnt = 0;
      ahead_cnt = 0;
      step_reg = StepReset;
      tol_reg = TolReset;
      fail_count_o = 0;
      pixel_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegWindowStep) step_reg = cfg_data_i[StepW-1:0];
        else if (cfg_idx_i == RegPairTol) tol_reg = cfg_data_i[TolW-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %0d/%0b", $time,
                   out_data_i.repaired_mm, out_data_i.column_done);
          fail_count_o++;
        end else begin
          exp_beat = pixel_q.pop_front();
          if (exp_beat.repaired_mm !== out_data_i.repaired_mm) begin
            $display("%0t: repaired_mm expected %0d actual %0d", $time,
                     exp_beat.repaired_mm, out_data_i.repaired_mm);
            fail_count_o++;
          end
          if (exp_beat.column_done !== out_data_i.column_done) begin
            $display("%0t: column_done expected %0b actual %0b", $time,
                     exp_beat.column_done, out_data_i.column_done);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_column(in_data_i);
    end
  end
endmodule

[tb/column_depth_gap_fill_top_tb.sv]
`timescale 1ns / 1ps
module column_depth_gap_fill_top_tb import cdgf_pkg::*;;
  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  in_beat_t        in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_beat_t       out_data_o;
  logic            cfg_we_i = 1'b0;
  logic [IdxW-1:0] cfg_idx_i = RegWindowStep;
  logic [CfgW-1:0] cfg_data_i = '0;
  int              fail_count;
  int              pending;
  int              cycle_count = 0;
  bit              long_hold = 1'b0;
  bit              stim_done = 1'b0;

  localparam int CycleLimit = 2000000;

  always #6 clk_i = ~clk_i;

  column_depth_gap_fill_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  column_depth_gap_fill_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random stall on the result side, with a long hold-off when asked
  always @(posedge clk_i) begin
    int unsigned g;
    if (long_hold) begin
      out_stall_i <= 1'b1;
      for (int k = 0; k < 300; k++) @(posedge clk_i);
      long_hold = 1'b0;
      out_stall_i <= 1'b0;
    end else if (stim_done || cycle_count % 2000 < 400) begin
      out_stall_i <= 1'b0;
    end else begin
      g = gap_len();
      out_stall_i <= (g != 0);
      for (int k = 1; k < g; k++) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays high after a beat unless a gap follows
  task automatic send_pixel(logic [DepthW-1:0] d, logic e, bit idle);
    int unsigned g;
    g = idle ? gap_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      for (int k = 0; k < g; k++) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{depth_mm: d, column_end: e};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    for (int k = 0; k < 120; k++) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DepthW-1:0] rand_depth(logic [DepthW-1:0] base);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 30) return '0;
    if (p < 35) return DepthW'($urandom_range(1, 2));
    if (p < 42) return DepthW'($urandom());
    return base + DepthW'($urandom_range(0, 1500));
  endfunction

  task automatic random_columns(int count, int max_len);
    int len;
    logic [DepthW-1:0] base;
    for (int c = 0; c < count; c++) begin
      len = $urandom_range(1, max_len);
      base = DepthW'($urandom_range(2, 260000));
      for (int p = 0; p < len; p++)
        send_pixel(rand_depth(base), (p == len - 1), 1'b1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, holes at column edges, tiny depths, single-pixel column
    send_pixel('0, 1'b0, 1'b0);
    send_pixel(18'd5000, 1'b0, 1'b0);
    send_pixel('0, 1'b0, 1'b0);
    send_pixel(18'd5400, 1'b0, 1'b0);
    send_pixel(18'd1, 1'b0, 1'b0);
    send_pixel('0, 1'b0, 1'b0);
    send_pixel(18'd2, 1'b0, 1'b0);
    send_pixel(18'h3FFFF, 1'b0, 1'b0);
    send_pixel('0, 1'b0, 1'b0);
    send_pixel(18'h3FFFE, 1'b0, 1'b0);
    send_pixel('0, 1'b1, 1'b0);
    send_pixel('0, 1'b1, 1'b0);
    send_pixel(18'h2AAAA, 1'b1, 1'b0);
    drain_wait();
    write_reg(RegPairTol, '0);
    write_reg(RegWindowStep, CfgW'(15));
    for (int k = 0; k < 6; k++) send_pixel((k % 2) ? 18'd3000 : 18'd0, k == 5, 1'b0);
    drain_wait();
    write_reg(RegPairTol, CfgW'(18'h3FFFF));
    write_reg(RegWindowStep, CfgW'(0));
    for (int k = 0; k < 4; k++) send_pixel((k == 1) ? 18'd0 : 18'h15555, k == 3, 1'b0);
    drain_wait();

    // random phases over several settings
    write_reg(RegWindowStep, CfgW'(2));
    write_reg(RegPairTol, CfgW'(800));
    random_columns(12, 10);
    drain_wait();
    write_reg(RegWindowStep, CfgW'(8));
    write_reg(RegPairTol, CfgW'(2000));
    long_hold = 1'b1;
    random_columns(12, 20);
    drain_wait();
    write_reg(RegWindowStep, CfgW'(1));
    write_reg(RegPairTol, CfgW'(18'h3FFFF));
    random_columns(6, 8);
    drain_wait();
    write_reg(RegWindowStep, CfgW'(5));
    write_reg(RegPairTol, CfgW'(1000));
    random_columns(12, 14);
    drain_wait();
    write_reg(RegWindowStep, CfgW'(12));
    write_reg(RegPairTol, CfgW'($urandom()));
    random_columns(10, 16);

    stim_done = 1'b1;
    drain_wait();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/cdgf_pkg.sv
rtl/core/cdgf_front.sv
rtl/core/cdgf_back.sv
rtl/core/column_depth_gap_fill_top.sv
tb/column_depth_gap_fill_checker.sv
tb/column_depth_gap_fill_top_tb.sv
